// ===== design/tif_pkg.sv =====
// Shared types, byte codes and result-word tables for the Telnet IAC filter.
`default_nettype none

package tif_pkg;

  localparam logic [7:0] B_SE      = 8'd240;
  localparam logic [7:0] B_NOP     = 8'd241;
  localparam logic [7:0] B_GA      = 8'd249;
  localparam logic [7:0] B_SB      = 8'd250;
  localparam logic [7:0] B_WILL    = 8'd251;
  localparam logic [7:0] B_WONT    = 8'd252;
  localparam logic [7:0] B_DO      = 8'd253;
  localparam logic [7:0] B_DONT    = 8'd254;
  localparam logic [7:0] B_IAC     = 8'd255;
  localparam logic [7:0] MCCP1_OPT = 8'd85;

  localparam logic [1:0] DEST_DATA  = 2'd0;
  localparam logic [1:0] DEST_REPLY = 2'd1;
  localparam logic [1:0] DEST_SUB   = 2'd2;
  localparam logic [1:0] DEST_END   = 2'd3;

  typedef enum logic [2:0] {
    ST_NORMAL,
    ST_IAC,
    ST_DONT,
    ST_DO,
    ST_WONT,
    ST_WILL,
    ST_SB,
    ST_SB_IAC
  } parse_state_t;

  // Shape of the run of result words that one input byte causes.
  typedef enum logic [2:0] {
    BK_DATA,
    BK_IAC_PAIR,
    BK_GA,
    BK_WONT_REPLY,
    BK_DONT_REPLY,
    BK_SUB,
    BK_SUB_PAIR,
    BK_END
  } burst_kind_t;

  typedef struct packed {
    logic        valid;
    burst_kind_t kind;
    logic [7:0]  data;
  } burst_t;

  function automatic logic [3:0] burst_len(input burst_kind_t kind);
    case (kind)
      BK_DATA:       burst_len = 4'd1;
      BK_IAC_PAIR:   burst_len = 4'd2;
      BK_GA:         burst_len = 4'd9;
      BK_WONT_REPLY: burst_len = 4'd3;
      BK_DONT_REPLY: burst_len = 4'd3;
      BK_SUB:        burst_len = 4'd1;
      BK_SUB_PAIR:   burst_len = 4'd2;
      BK_END:        burst_len = 4'd1;
      default:       burst_len = 4'd1;
    endcase
  endfunction

  // The text "<IAC><GA>" that stands in for a go-ahead.
  function automatic logic [7:0] ga_char(input logic [3:0] idx);
    case (idx)
      4'd0:    ga_char = 8'h3C;
      4'd1:    ga_char = 8'h49;
      4'd2:    ga_char = 8'h41;
      4'd3:    ga_char = 8'h43;
      4'd4:    ga_char = 8'h3E;
      4'd5:    ga_char = 8'h3C;
      4'd6:    ga_char = 8'h47;
      4'd7:    ga_char = 8'h41;
      4'd8:    ga_char = 8'h3E;
      default: ga_char = 8'h3E;
    endcase
  endfunction

  function automatic logic [7:0] word_byte(input burst_kind_t kind, input logic [3:0] idx,
                                           input logic [7:0] data);
    case (kind)
      BK_DATA, BK_SUB:         word_byte = data;
      BK_IAC_PAIR, BK_SUB_PAIR: word_byte = (idx == 4'd0) ? B_IAC : data;
      BK_GA:                   word_byte = ga_char(idx);
      BK_WONT_REPLY:
        word_byte = (idx == 4'd0) ? B_IAC : (idx == 4'd1) ? B_WONT : data;
      BK_DONT_REPLY:
        word_byte = (idx == 4'd0) ? B_IAC : (idx == 4'd1) ? B_DONT : data;
      BK_END:                  word_byte = B_SE;
      default:                 word_byte = data;
    endcase
  endfunction

  function automatic logic [1:0] word_dest(input burst_kind_t kind);
    case (kind)
      BK_WONT_REPLY, BK_DONT_REPLY: word_dest = DEST_REPLY;
      BK_SUB, BK_SUB_PAIR:          word_dest = DEST_SUB;
      BK_END:                       word_dest = DEST_END;
      default:                      word_dest = DEST_DATA;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/tif_if.sv =====
// Valid/ready channel interfaces for the received byte and the result word.
`default_nettype none

interface tif_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] dest;
  logic       last;

  modport source (output valid, output out_byte, output dest, output last, input ready);
  modport sink (input valid, input out_byte, input dest, input last, output ready);
endinterface

`default_nettype wire

// ===== design/tif_parser.sv =====
// Input register and Telnet parse state; turns each byte that yields results into a result-run descriptor.
`default_nettype none

module tif_parser (
  input  logic            clk,
  input  logic            rst,
  tif_in_if.sink          in,
  input  logic            free,
  output tif_pkg::burst_t burst
);
  import tif_pkg::*;

  logic         full;
  logic [7:0]   in_reg;
  parse_state_t state, state_next;
  logic [1:0]   sub_count, sub_count_next;
  logic [7:0]   sub_first, sub_first_next;
  logic [7:0]   sub_second, sub_second_next;
  logic         move;
  logic         emit;
  burst_kind_t  kind;

  // A held byte moves on once the emitter can take its run of words.
  assign move     = full && free;
  assign in.ready = !full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in.valid && in.ready) begin
      full <= 1'b1;
    end else if (move) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      in_reg <= in.in_byte;
    end
  end

  always_comb begin
    state_next      = state;
    sub_count_next  = sub_count;
    sub_first_next  = sub_first;
    sub_second_next = sub_second;
    emit            = 1'b0;
    kind            = BK_DATA;
    case (state)
      ST_NORMAL: begin
        if (in_reg == B_IAC) begin
          state_next = ST_IAC;
        end else begin
          emit = 1'b1;
        end
      end
      ST_IAC: begin
        state_next = ST_NORMAL;
        case (in_reg)
          B_DONT: state_next = ST_DONT;
          B_DO:   state_next = ST_DO;
          B_WONT: state_next = ST_WONT;
          B_WILL: state_next = ST_WILL;
          B_SB: begin
            sub_count_next = 2'd0;
            state_next     = ST_SB;
          end
          B_GA: begin
            emit = 1'b1;
            kind = BK_GA;
          end
          B_IAC: begin
            emit = 1'b1;
          end
          B_NOP: begin
            emit = 1'b0;
          end
          default: begin
            emit = 1'b1;
            kind = BK_IAC_PAIR;
          end
        endcase
      end
      ST_DO: begin
        emit       = 1'b1;
        kind       = BK_WONT_REPLY;
        state_next = ST_NORMAL;
      end
      ST_WILL: begin
        emit       = 1'b1;
        kind       = BK_DONT_REPLY;
        state_next = ST_NORMAL;
      end
      ST_DONT, ST_WONT: begin
        state_next = ST_NORMAL;
      end
      ST_SB: begin
        if (in_reg == B_IAC) begin
          state_next = ST_SB_IAC;
        end else if (in_reg == B_SE && sub_count == 2'd2 && sub_first == MCCP1_OPT
                     && sub_second == B_WILL) begin
          emit       = 1'b1;
          kind       = BK_END;
          state_next = ST_NORMAL;
        end else begin
          emit = 1'b1;
          kind = BK_SUB;
          if (sub_count == 2'd0) begin
            sub_first_next = in_reg;
          end else if (sub_count == 2'd1) begin
            sub_second_next = in_reg;
          end
          sub_count_next = (sub_count == 2'd3) ? 2'd3 : sub_count + 2'd1;
        end
      end
      ST_SB_IAC: begin
        emit = 1'b1;
        if (in_reg == B_SE) begin
          kind       = BK_END;
          state_next = ST_NORMAL;
        end else begin
          // The escaped 255 and this byte both count as content.
          kind       = BK_SUB_PAIR;
          state_next = ST_SB;
          if (sub_count == 2'd0) begin
            sub_first_next  = B_IAC;
            sub_second_next = in_reg;
          end else if (sub_count == 2'd1) begin
            sub_second_next = B_IAC;
          end
          sub_count_next = (sub_count >= 2'd2) ? 2'd3 : sub_count + 2'd2;
        end
      end
      default: begin
        state_next = ST_NORMAL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_NORMAL;
      sub_count  <= 2'd0;
      sub_first  <= 8'd0;
      sub_second <= 8'd0;
    end else if (move) begin
      state      <= state_next;
      sub_count  <= sub_count_next;
      sub_first  <= sub_first_next;
      sub_second <= sub_second_next;
    end
  end

  assign burst.valid = move && emit;
  assign burst.kind  = kind;
  assign burst.data  = in_reg;

endmodule

`default_nettype wire

// ===== design/tif_emitter.sv =====
// Result register that plays out a run of words, one per accepted output handshake.
`default_nettype none

module tif_emitter (
  input  logic            clk,
  input  logic            rst,
  input  tif_pkg::burst_t burst,
  output logic            free,
  tif_out_if.source       out
);
  import tif_pkg::*;

  logic        busy;
  burst_kind_t kind;
  logic [7:0]  data;
  logic [3:0]  idx;
  logic        final_word;

  assign final_word = (idx == burst_len(kind) - 4'd1);
  assign free       = !busy || (out.ready && final_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (free) begin
      busy <= burst.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && burst.valid) begin
      kind <= burst.kind;
      data <= burst.data;
      idx  <= 4'd0;
    end else if (busy && out.ready && !final_word) begin
      idx <= idx + 4'd1;
    end
  end

  assign out.valid    = busy;
  assign out.out_byte = word_byte(kind, idx, data);
  assign out.dest     = word_dest(kind);
  assign out.last     = final_word;

endmodule

`default_nettype wire

// ===== design/telnet_iac_filter_unit.sv =====
// Top level of the Telnet IAC filter: input register, parser and result emitter.
//
// Usage: received Telnet bytes enter on the in channel (in_byte), one per word.
// Results leave on the out channel as words of out_byte, dest and last: dest 0
// is data onward, 1 a reply to the sender, 2 subnegotiation content and 3 the
// subnegotiation end marker. last marks the final word caused by one byte.
// Bytes that cause no result (IAC, option commands, NOP, DONT x, WONT x) only
// advance the parse state.
// A byte waits in the input register until the emitter is free, then moves to
// the result register, which shows its first result word. Throughput: one byte
// per cycle while each byte yields at most one word and the receiver takes each
// word; a byte yielding several words holds the output until its last word is
// taken (three words for a reply, nine for a go-ahead), and the input register
// absorbs one more byte. A receiver stall holds the current word stable; the
// input register fills and in.ready stays low until the run's last word is taken.
// Reset (synchronous rst) empties both registers and returns to the normal
// data state with the subnegotiation count and saved bytes cleared.
`default_nettype none

module telnet_iac_filter_unit (
  input  logic      clk,
  input  logic      rst,
  tif_in_if.sink    in,
  tif_out_if.source out
);
  import tif_pkg::*;

  burst_t burst;
  logic   free;

  tif_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .in    (in),
    .free  (free),
    .burst (burst)
  );

  tif_emitter u_emitter (
    .clk   (clk),
    .rst   (rst),
    .burst (burst),
    .free  (free),
    .out   (out)
  );

endmodule

`default_nettype wire

// ===== design/tif_checker.sv =====
// Port-level checks for the Telnet IAC filter and their binding to the top level.
`default_nettype none

module tif_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] dest,
  input logic       last
);
  import tif_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(dest)
      && $stable(last))
    else $error("stalled result word changed");

  // The end marker stands alone and carries the SE code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && dest == DEST_END |-> last && out_byte == B_SE)
    else $error("malformed end marker");

  // A reply run continues without gaps on the reply destination.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && dest == DEST_REPLY && !last |=> out_valid && dest == DEST_REPLY)
    else $error("reply run broken");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind telnet_iac_filter_unit tif_checker u_tif_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .out_byte  (out.out_byte),
  .dest      (out.dest),
  .last      (out.last)
);

`default_nettype wire
